// ===== src/signed_divider_quotient_remainder_defines.svh =====
// Assertion helpers for the divider checker.
`ifndef SIGNED_DIVIDER_QUOTIENT_REMAINDER_DEFINES_SVH
`define SIGNED_DIVIDER_QUOTIENT_REMAINDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SDQR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SDQR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sdqr_pkg.sv =====
`default_nettype none

package sdqr_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

   typedef struct packed {
      logic signed [WIDTH-1:0] numerator;
      logic signed [WIDTH-1:0] denominator;
   } req_type;

   typedef struct packed {
      logic signed [WIDTH-1:0] quotient;
      logic signed [WIDTH-1:0] remainder;
      logic                    zero_divisor;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture operands, take magnitudes
      logic step;    // one restoring step
      logic finish;  // sign fix-up into the result register
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX
   } state_type;

endpackage

`default_nettype wire

// ===== src/sdqr_dpath.sv =====
`default_nettype none

module sdqr_dpath
   import sdqr_pkg::*;
(
   input  wire logic    clock,
   input  wire req_type req,
   input  wire cmd_type cmd,
   output rsp_type      rsp
);

   logic             n_neg_ff, n_neg_in;
   logic             d_neg_ff, d_neg_in;
   logic             zero_ff, zero_in;
   logic [WIDTH-1:0] mag_d_ff, mag_d_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   rsp_type          rsp_ff, rsp_in;

   logic [WIDTH-1:0] num_u, den_u;
   logic [WIDTH:0]   shifted, divisor_x, diff;
   logic             ge;
   logic [WIDTH-1:0] q_fix, r_fix;

   always_comb begin
      num_u = WIDTH'(req.numerator);
      den_u = WIDTH'(req.denominator);

      shifted   = {rem_ff, quo_ff[WIDTH-1]};
      divisor_x = {1'b0, mag_d_ff};
      diff      = shifted - divisor_x;
      ge        = (shifted >= divisor_x);

      q_fix = (n_neg_ff != d_neg_ff) ? ('0 - quo_ff) : quo_ff;
      r_fix = n_neg_ff ? ('0 - rem_ff) : rem_ff;

      n_neg_in = n_neg_ff;
      d_neg_in = d_neg_ff;
      zero_in  = zero_ff;
      mag_d_in = mag_d_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      rsp_in   = rsp_ff;

      if (cmd.load) begin
         n_neg_in = num_u[WIDTH-1];
         d_neg_in = den_u[WIDTH-1];
         zero_in  = (den_u == '0);
         mag_d_in = den_u[WIDTH-1] ? ('0 - den_u) : den_u;
         quo_in   = num_u[WIDTH-1] ? ('0 - num_u) : num_u;
         rem_in   = '0;
      end else if (cmd.step) begin
         // remainder stays below the divisor, so the low WIDTH bits suffice
         rem_in = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ge};
      end

      if (cmd.finish) begin
         rsp_in.quotient     = zero_ff ? '0 : q_fix;
         rsp_in.remainder    = zero_ff ? '0 : r_fix;
         rsp_in.zero_divisor = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_neg_ff <= n_neg_in;
      d_neg_ff <= d_neg_in;
      zero_ff  <= zero_in;
      mag_d_ff <= mag_d_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

// ===== src/sdqr_ctrl.sv =====
`default_nettype none

module sdqr_ctrl
   import sdqr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   // result register can take a new beat
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
         end
         ST_FIX: begin
            cmd.finish = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/signed_divider_quotient_remainder.sv =====
// Signed divide, quotient truncated toward zero, remainder with the dividend's sign.
// The req beat loads the operands, then one restoring subtract/compare step runs per
// quotient bit, then a sign fix-up writes the result register and raises rsp_valid.
// One item at a time: no new req is taken before that fix-up, which waits while rsp stalls.
// A new req beat is taken while the previous result still waits in the output register.
// Synchronous active-high reset idles the controller and clears rsp_valid.
`default_nettype none

module signed_divider_quotient_remainder
   import sdqr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   cmd_type cmd;

   sdqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sdqr_dpath u_dpath (
      .clock (clock),
      .req   (req),
      .cmd   (cmd),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

// ===== src/sdqr_checker.sv =====
`default_nettype none
`include "signed_divider_quotient_remainder_defines.svh"

module sdqr_checker
   import sdqr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp
);

   logic req_fire;
   logic rsp_nonzero;

   assign req_fire    = req_valid && req_ready;
   assign rsp_nonzero = (rsp.quotient != '0) || (rsp.remainder != '0);

   // stalled result beat holds
   `SDQR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp moved")

   // zero divisor beats carry zero results
   `SDQR_ASSERT_NOW(a_zero_res, rsp_valid && rsp.zero_divisor, !rsp_nonzero, "nonzero result")

   // one item in flight: busy right after a req beat
   `SDQR_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "req taken while busy")

   // no result can appear the cycle after a req beat
   `SDQR_ASSERT_NEXT(a_no_early_rsp, req_fire, !$rose(rsp_valid), "result too early")

endmodule

bind signed_divider_quotient_remainder sdqr_checker u_sdqr_checker (.*);

`default_nettype wire
